// ----- hw/rtl/spdt_switch_gain_ramp_assert.svh -----
// Assertion macros used by the checker file of the switch block.
`ifndef SPDT_SWITCH_GAIN_RAMP_ASSERT_SVH
`define SPDT_SWITCH_GAIN_RAMP_ASSERT_SVH

// The consequent is checked at the same edge as the antecedent.
`define SPDT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked at the next edge after the antecedent.
`define SPDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spdt_pkg.sv -----
package spdt_pkg;

  localparam int SAMPLE_WIDTH_DEF      = 16;
  localparam int COUNT_WIDTH_DEF       = 16;
  localparam int CONTROL_THRESHOLD_DEF = 16384;

  localparam int GAIN_W      = 16;
  localparam int LEN_W       = 16;
  localparam int PROD_W      = GAIN_W + LEN_W;
  localparam int FRAC_W      = 15;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ON_GAIN_1      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_GAIN_1     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ON_GAIN_2      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_GAIN_2     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ON_LEN_1  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OFF_LEN_1 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ON_LEN_2  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OFF_LEN_2 = CFG_IDX_W'(7);

  localparam logic [GAIN_W-1:0] ON_GAIN_RST  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] OFF_GAIN_RST = GAIN_W'(0);
  localparam logic [LEN_W-1:0]  LEN_RST      = LEN_W'(0);

  typedef struct packed {
    logic [GAIN_W-1:0] on_gain_1;
    logic [GAIN_W-1:0] off_gain_1;
    logic [GAIN_W-1:0] on_gain_2;
    logic [GAIN_W-1:0] off_gain_2;
    logic [LEN_W-1:0]  turn_on_len_1;
    logic [LEN_W-1:0]  turn_off_len_1;
    logic [LEN_W-1:0]  turn_on_len_2;
    logic [LEN_W-1:0]  turn_off_len_2;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [LEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/spdt_switch_gain_ramp.sv -----
// Two-port RF switch model with linear gain ramps on each port.
// in_*: one beat per complex envelope sample plus its control level. A
// control level above the threshold selects port 1, otherwise port 2.
// out_*: one beat per input beat, the sample scaled by each port's gain.
// cfg_*: register writes (gains and ramp lengths); cfg_ready is always high,
// and writes are meant for times when no beat is in flight.
// A front stage takes input beats, updates the selection and ramp index
// and queues up to four entries; a back stage works them off one at a time.
// Each ramping port takes one division in a 16-step shared divider.
// In the back stage an entry passes the idle state, a gain state per port,
// a division start and wait for each ramping port, then the multiply and
// output states; a new entry is taken only once the last one is through.
// Reset selects port 2, clears the ramp index, loads the default gains and
// zero lengths, and empties the queue and the output register.
// When the receiver stalls, the output beat holds, the back stage finishes
// the next entry and waits, and in_tready drops once the queue is full.
module spdt_switch_gain_ramp import spdt_pkg::*; #(
  parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF,
  parameter int CONTROL_THRESHOLD = CONTROL_THRESHOLD_DEF,
  localparam int IN_W             = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W            = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // in_i, in_q, ctrl_level
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // out1_i, out1_q, out2_i, out2_q
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ENT_W = 2 * SAMPLE_WIDTH + 1 + COUNT_WIDTH;

  cfg_t             cfg_r;
  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [ENT_W-1:0] rdata;
  logic             empty;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_gain_1      <= ON_GAIN_RST;
      cfg_r.off_gain_1     <= OFF_GAIN_RST;
      cfg_r.on_gain_2      <= ON_GAIN_RST;
      cfg_r.off_gain_2     <= OFF_GAIN_RST;
      cfg_r.turn_on_len_1  <= LEN_RST;
      cfg_r.turn_off_len_1 <= LEN_RST;
      cfg_r.turn_on_len_2  <= LEN_RST;
      cfg_r.turn_off_len_2 <= LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ON_GAIN_1:      cfg_r.on_gain_1      <= cfg_data;
        REG_OFF_GAIN_1:     cfg_r.off_gain_1     <= cfg_data;
        REG_ON_GAIN_2:      cfg_r.on_gain_2      <= cfg_data;
        REG_OFF_GAIN_2:     cfg_r.off_gain_2     <= cfg_data;
        REG_TURN_ON_LEN_1:  cfg_r.turn_on_len_1  <= cfg_data;
        REG_TURN_OFF_LEN_1: cfg_r.turn_off_len_1 <= cfg_data;
        REG_TURN_ON_LEN_2:  cfg_r.turn_on_len_2  <= cfg_data;
        REG_TURN_OFF_LEN_2: cfg_r.turn_off_len_2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spdt_front #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .COUNT_WIDTH       (COUNT_WIDTH),
    .CONTROL_THRESHOLD (CONTROL_THRESHOLD),
    .IN_W              (IN_W),
    .ENT_W             (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  spdt_fifo #(
    .WIDTH (ENT_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  spdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  spdt_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .ENT_W        (ENT_W),
    .OUT_W        (OUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .empty      (empty),
    .rdata      (rdata),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/spdt_front.sv -----
module spdt_front import spdt_pkg::*; #(
  parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF,
  parameter int CONTROL_THRESHOLD = CONTROL_THRESHOLD_DEF,
  parameter int IN_W              = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int ENT_W             = 2 * SAMPLE_WIDTH + 1 + COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             full,
  output logic             push,
  output logic [ENT_W-1:0] push_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam logic signed [32:0] THR_X = 33'(CONTROL_THRESHOLD);

  logic                   sel_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] k;
  logic [SW-1:0]          ctrl;
  logic signed [32:0]     ctrl_x;
  logic                   high;

  assign in_tready = !full;
  assign push      = in_tvalid && !full;
  assign ctrl      = in_tdata[3*SW-1:2*SW];
  assign ctrl_x    = {{(33-SW){ctrl[SW-1]}}, ctrl};
  assign high      = ctrl_x > THR_X;

  // A change of selection restarts the ramp index for this very beat.
  assign k         = (high != sel_r) ? '0 : count_r;
  assign count_nxt = (&k) ? k : k + 1'b1;
  assign push_data = {k, high, in_tdata[2*SW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      count_r <= '0;
    end else if (push) begin
      sel_r   <= high;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/spdt_fifo.sv -----
module spdt_fifo import spdt_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;

  assign full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/spdt_div.sv -----
module spdt_div import spdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // The quotient is known to fit GAIN_W bits, so the upper half of the
  // dividend is already below the divisor and only GAIN_W steps are needed.
  localparam int STEPS = GAIN_W;
  localparam int CNT_W = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  rem_r;
  logic [GAIN_W-1:0] quo_r;
  logic [LEN_W-1:0]  dvs_r;
  logic [LEN_W:0]    trial;
  logic              ge;
  logic [LEN_W-1:0]  rem_nxt;
  logic [GAIN_W-1:0] quo_nxt;

  assign trial   = {rem_r, quo_r[GAIN_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? LEN_W'(trial - {1'b0, dvs_r}) : trial[LEN_W-1:0];
  assign quo_nxt = {quo_r[GAIN_W-2:0], ge};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[PROD_W-1:GAIN_W];
      quo_r <= req.dividend[GAIN_W-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// ----- hw/rtl/spdt_back.sv -----
module spdt_back import spdt_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int ENT_W        = 2 * SAMPLE_WIDTH + 1 + COUNT_WIDTH,
  parameter int OUT_W        = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             empty,
  input  logic [ENT_W-1:0] rdata,
  output logic             pop,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COUNT_WIDTH;
  localparam int KW = (CW > LEN_W) ? CW : LEN_W;
  localparam int PW = SW + GAIN_W + 1;
  localparam logic signed [PW-1:0] MAX_V = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] MIN_V = ~MAX_V;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAIN   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic                    port_r;
  logic                    port_nxt;
  logic [SW-1:0]           xi_r;
  logic [SW-1:0]           xq_r;
  logic                    sel_r;
  logic [CW-1:0]           k_r;
  logic [GAIN_W-1:0]       gain1_r;
  logic [GAIN_W-1:0]       gain2_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [PW-1:0]    p_r [4];
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  logic                    turning_on;
  logic [GAIN_W-1:0]       on_g;
  logic [GAIN_W-1:0]       off_g;
  logic [LEN_W-1:0]        len;
  logic [KW-1:0]           k_ext;
  logic                    at_end;
  logic                    span_neg;
  logic [GAIN_W-1:0]       mag;
  logic [LEN_W-1:0]        pos;
  logic [GAIN_W-1:0]       end_gain;
  logic [GAIN_W-1:0]       fix_gain;
  logic                    store_gain;
  logic [GAIN_W-1:0]       gain_val;
  logic                    out_free;
  logic signed [PW-1:0]    sh [4];
  logic [SW-1:0]           lane [4];

  // Port 1 is lane 0 of port_r, port 2 is lane 1.
  assign turning_on = port_r ? !sel_r : sel_r;
  assign on_g       = port_r ? cfg.on_gain_2 : cfg.on_gain_1;
  assign off_g      = port_r ? cfg.off_gain_2 : cfg.off_gain_1;
  always_comb begin
    if (turning_on) begin
      len = port_r ? cfg.turn_on_len_2 : cfg.turn_on_len_1;
    end else begin
      len = port_r ? cfg.turn_off_len_2 : cfg.turn_off_len_1;
    end
  end

  assign k_ext    = KW'(k_r);
  assign at_end   = k_ext >= KW'(len);
  assign span_neg = off_g > on_g;
  assign mag      = span_neg ? off_g - on_g : on_g - off_g;
  // Below the end of the ramp the index fits the length width.
  assign pos      = turning_on ? k_ext[LEN_W-1:0] : len - k_ext[LEN_W-1:0];
  assign end_gain = turning_on ? on_g : off_g;
  // The quotient never exceeds the span, so the gain stays between off and on.
  assign fix_gain = span_neg ? off_g - div_rsp.quotient : off_g + div_rsp.quotient;

  assign div_req.start    = state_r == S_DSTART;
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = len;

  assign out_free   = !out_valid_r || out_tready;
  assign pop        = (state_r == S_IDLE) && !empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    port_nxt   = port_r;
    store_gain = 1'b0;
    gain_val   = end_gain;
    unique case (state_r)
      S_IDLE: begin
        if (!empty) begin
          state_nxt = S_GAIN;
          port_nxt  = 1'b0;
        end
      end
      S_GAIN: begin
        if (at_end) begin
          store_gain = 1'b1;
          if (port_r) begin
            state_nxt = S_MUL;
          end else begin
            port_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        gain_val = fix_gain;
        if (div_rsp.done) begin
          store_gain = 1'b1;
          if (port_r) begin
            state_nxt = S_MUL;
          end else begin
            port_nxt  = 1'b1;
            state_nxt = S_GAIN;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sh[j] = p_r[j] >>> FRAC_W;
      if (sh[j] > MAX_V) begin
        lane[j] = MAX_V[SW-1:0];
      end else if (sh[j] < MIN_V) begin
        lane[j] = MIN_V[SW-1:0];
      end else begin
        lane[j] = sh[j][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      port_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      port_r  <= port_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      xi_r  <= rdata[SW-1:0];
      xq_r  <= rdata[2*SW-1:SW];
      sel_r <= rdata[2*SW];
      k_r   <= rdata[2*SW+CW:2*SW+1];
    end
    if (state_r == S_GAIN) begin
      prod_r <= mag * pos;
    end
    if (store_gain) begin
      if (port_r) begin
        gain2_r <= gain_val;
      end else begin
        gain1_r <= gain_val;
      end
    end
    if (state_r == S_MUL) begin
      p_r[0] <= $signed(xi_r) * $signed({1'b0, gain1_r});
      p_r[1] <= $signed(xq_r) * $signed({1'b0, gain1_r});
      p_r[2] <= $signed(xi_r) * $signed({1'b0, gain2_r});
      p_r[3] <= $signed(xq_r) * $signed({1'b0, gain2_r});
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= OUT_W'({lane[3], lane[2], lane[1], lane[0]});
    end
  end

endmodule

// ----- hw/rtl/spdt_chk.sv -----
`include "spdt_switch_gain_ramp_assert.svh"

module spdt_chk #(
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // Out of reset the queue and the output register are empty.
  `SPDT_ASSERT_SAME(a_reset_clean, $past(!rst_n), in_tready && !out_tvalid && cfg_ready, "not clean after reset")

  // The queue only fills up through an accepted input beat.
  `SPDT_ASSERT_SAME(a_ready_drop, $fell(in_tready), $past(in_tvalid && in_tready), "in_tready fell without a beat")

  `SPDT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped while stalled")

  `SPDT_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out_tdata changed while stalled")

  // The configuration channel never back-pressures.
  `SPDT_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "cfg_ready low during a write")

endmodule

bind spdt_switch_gain_ramp spdt_chk #(.OUT_W(OUT_W)) u_spdt_chk (.*);
